FILE: sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame decoder package
// Frame layout constants, status codes, result type and the CRC byte update.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int unsigned FRAME_W      = 168;   // 21 bytes, byte 0 at the top
    localparam logic [4:0]  FRAME_BYTES  = 5'd21;
    localparam logic [4:0]  CRC_BYTES    = 5'd19;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [7:0]  VERSION_INIT = 8'h01;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_SHORT       = 2'd1,
        STATUS_BAD_VERSION = 2'd2,
        STATUS_BAD_CRC     = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [7:0]         frame_version;
        logic [15:0]        device_id;
        logic [15:0]        sequence_number;
        logic [31:0]        uptime_seconds;
        logic signed [15:0] temperature_centi;
        logic [15:0]        humidity_centi;
        logic [23:0]        pressure_deci_pa;
        logic [23:0]        gas_reading;
        logic [15:0]        received_crc;
    } result_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first, unrolled over eight bits
    function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: sv/sfd_ifs.sv
// ----------------------------------------------------------------------------
// Sensor frame decoder channels
// Valid/ready channels for received bytes, decoded results and configuration.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface sfd_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         frame_version;
    logic [15:0]        device_id;
    logic [15:0]        sequence_number;
    logic [31:0]        uptime_seconds;
    logic signed [15:0] temperature_centi;
    logic [15:0]        humidity_centi;
    logic [23:0]        pressure_deci_pa;
    logic [23:0]        gas_reading;
    logic [15:0]        received_crc;

    modport source (output valid, output status, output frame_version, output device_id,
                    output sequence_number, output uptime_seconds,
                    output temperature_centi, output humidity_centi,
                    output pressure_deci_pa, output gas_reading, output received_crc,
                    input ready);
    modport sink   (input valid, input status, input frame_version, input device_id,
                    input sequence_number, input uptime_seconds,
                    input temperature_centi, input humidity_centi,
                    input pressure_deci_pa, input gas_reading, input received_crc,
                    output ready);
endinterface

interface sfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/sensor_frame_decoder_crc16.sv
// ----------------------------------------------------------------------------
// Sensor frame decoder with CRC-16 check
// Decodes a 21-byte big-endian sensor frame received one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   byte_ch   : one received byte per transaction; last_byte marks the end of
//               the buffer. Bytes past the 21st are dropped from decoding.
//   result_ch : one transaction per flagged byte, carrying status and fields.
//               A too-short buffer returns every field as zero.
//   cfg_ch    : writes expected_version (reset value 1); always ready. Write
//               only while no frame is in progress.
// Throughput: one byte per cycle while byte_ch.ready is high. The CRC update
//   is an eight-bit unrolled step, done in the same cycle as the byte capture.
// Output: the result is registered in the output register, or in the skid entry.
// Stall: an output register plus one skid entry hold results; bytes keep
//   flowing while one result waits, and byte_ch.ready drops only when both
//   are full.
// Reset: clears byte count, CRC (to 0xFFFF), result valids and the version
//   register back to 1. After each result the decoder clears for a new frame.
// ----------------------------------------------------------------------------
module sensor_frame_decoder_crc16
(
    input  logic  clk,
    input  logic  rst_n,
    sfd_byte_if.sink     byte_ch,
    sfd_result_if.source result_ch,
    sfd_cfg_if.sink      cfg_ch
);

    logic [7:0]       expected_version_reg;
    logic [7:0]       expected_version_next;
    logic             accept;
    logic             res_valid;
    sfd_pkg::result_t res;
    logic             space;
    sfd_pkg::result_t out_data;

    // Configuration: take every write, hold otherwise
    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        expected_version_next = expected_version_reg;
        if (cfg_ch.valid)
            expected_version_next = cfg_ch.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_version_reg <= sfd_pkg::VERSION_INIT;
        else
            expected_version_reg <= expected_version_next;
    end

    // Byte transaction completes when the buffer still has room for a result
    assign byte_ch.ready = space;
    assign accept        = byte_ch.valid && space;

    sfd_frame_capture u_capture
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .rx_byte          (byte_ch.rx_byte),
        .last_byte        (byte_ch.last_byte),
        .expected_version (expected_version_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    sfd_result_buffer u_buffer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .out_data  (out_data)
    );

    assign result_ch.status            = out_data.status;
    assign result_ch.frame_version     = out_data.frame_version;
    assign result_ch.device_id         = out_data.device_id;
    assign result_ch.sequence_number   = out_data.sequence_number;
    assign result_ch.uptime_seconds    = out_data.uptime_seconds;
    assign result_ch.temperature_centi = out_data.temperature_centi;
    assign result_ch.humidity_centi    = out_data.humidity_centi;
    assign result_ch.pressure_deci_pa  = out_data.pressure_deci_pa;
    assign result_ch.gas_reading       = out_data.gas_reading;
    assign result_ch.received_crc      = out_data.received_crc;

endmodule

FILE: sv/sfd_frame_capture.sv
// ----------------------------------------------------------------------------
// Sensor frame capture
// Byte count, running CRC and frame bytes; builds a result on the last byte.
// ----------------------------------------------------------------------------
module sfd_frame_capture
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    input  logic             last_byte,
    input  logic [7:0]       expected_version,
    output logic             res_valid,
    output sfd_pkg::result_t res
);

    logic [4:0]                   count_reg;
    logic [4:0]                   count_next;
    logic [15:0]                  crc_reg;
    logic [15:0]                  crc_next;
    logic [sfd_pkg::FRAME_W-1:0]  frame_reg;
    logic [sfd_pkg::FRAME_W-1:0]  frame_next;

    logic [4:0]                   count_cap;
    logic [15:0]                  crc_cap;
    logic [sfd_pkg::FRAME_W-1:0]  frame_cap;
    sfd_pkg::status_t             status;

    // Place the byte, advance the CRC over the covered bytes, saturate the count
    always_comb
    begin
        count_cap = count_reg;
        crc_cap   = crc_reg;
        frame_cap = frame_reg;
        if (count_reg < sfd_pkg::FRAME_BYTES)
        begin
            for (int i = 0; i < 21; i++)
            begin
                if (count_reg == 5'(i))
                    frame_cap[sfd_pkg::FRAME_W-8-8*i +: 8] = rx_byte;
            end
            if (count_reg < sfd_pkg::CRC_BYTES)
                crc_cap = sfd_pkg::crc_update(crc_reg, rx_byte);
            count_cap = count_reg + 5'd1;
        end
    end

    always_comb
    begin
        priority if (count_cap < sfd_pkg::FRAME_BYTES)
            status = sfd_pkg::STATUS_SHORT;
        else if (frame_cap[167:160] != expected_version)
            status = sfd_pkg::STATUS_BAD_VERSION;
        else if (crc_cap != frame_cap[15:0])
            status = sfd_pkg::STATUS_BAD_CRC;
        else
            status = sfd_pkg::STATUS_OK;
    end

    always_comb
    begin
        res                   = '0;
        res.status            = status;
        if (status != sfd_pkg::STATUS_SHORT)
        begin
            res.frame_version     = frame_cap[167:160];
            res.device_id         = frame_cap[159:144];
            res.sequence_number   = frame_cap[143:128];
            res.uptime_seconds    = frame_cap[127:96];
            res.temperature_centi = frame_cap[95:80];
            res.humidity_centi    = frame_cap[79:64];
            res.pressure_deci_pa  = frame_cap[63:40];
            res.gas_reading       = frame_cap[39:16];
            res.received_crc      = frame_cap[15:0];
        end
    end

    assign res_valid = accept && last_byte;

    // Clear count and CRC after a result; stale frame bytes stay until a full frame overwrites them
    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        frame_next = frame_reg;
        if (accept)
        begin
            frame_next = frame_cap;
            if (last_byte)
            begin
                count_next = '0;
                crc_next   = sfd_pkg::CRC_INIT;
            end
            else
            begin
                count_next = count_cap;
                crc_next   = crc_cap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= sfd_pkg::CRC_INIT;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

endmodule

FILE: sv/sfd_result_buffer.sv
// ----------------------------------------------------------------------------
// Sensor frame result buffer
// Output register with a skid entry so bytes keep flowing while a result waits.
// ----------------------------------------------------------------------------
module sfd_result_buffer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  sfd_pkg::result_t res,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output sfd_pkg::result_t out_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    sfd_pkg::result_t out_data_reg;
    sfd_pkg::result_t out_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    sfd_pkg::result_t skid_data_reg;
    sfd_pkg::result_t skid_data_next;
    logic             pop;

    assign pop   = out_valid_reg && out_ready;
    assign space = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // no new result can arrive while the skid entry is full
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_next = res_valid;
            out_data_next  = res;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: verif/tb_sensor_frame_decoder_crc16.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor frame decoder testbench
// Sends byte buffers over the byte channel and tracks each byte with a
// bit-level model of the frame decoder. Every decoded result is checked field
// by field against the oldest expected frame. The tests cover directed frames,
// version register settings, output back-pressure and random traffic under
// three idling mixes.
// ----------------------------------------------------------------------------
module tb_sensor_frame_decoder_crc16;

    typedef logic [7:0] byte_q_t[$];

    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 4;
    localparam int RANDOM_PHASE_N  = 45;     // bytes per random phase, at least
    localparam int PHASE_FRAMES    = 3;      // decoded frames per random phase, at least

    logic clk;
    logic rst_n;

    sfd_byte_if   byte_if();
    sfd_result_if res_if();
    sfd_cfg_if    cfg_if();

    sensor_frame_decoder_crc16 i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_if),
        .result_ch (res_if),
        .cfg_ch    (cfg_if)
    );

    // ------------------------------------------------------------------------
    // Decoder model state: the captured frame is held as one 168-bit vector,
    // byte 0 in the top eight bits, exactly as it sits on the wire.
    // ------------------------------------------------------------------------
    logic [167:0] frame_bits;
    logic [4:0]   frame_fill;
    logic [15:0]  frame_crc;
    logic [7:0]   version_cfg;

    sfd_pkg::result_t expected_frames[$];

    // Idling controls, shared by the driver and the result receiver
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_left;

    // Run statistics
    int bytes_sent;
    int frames_seen;
    int mismatches;
    int stalled_cycles;
    int version_writes;
    int cycle_count;
    int status_seen[4];

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // CRC-16/CCITT-FALSE, one bit at a time: feed back the top bit xor the
    // incoming data bit, most significant data bit first.
    // ------------------------------------------------------------------------
    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ sfd_pkg::CRC_POLY;
        end
        return c;
    endfunction

    function automatic void clear_frame_model();
        frame_bits = '0;
        frame_fill = '0;
        frame_crc  = sfd_pkg::CRC_INIT;
    endfunction

    // Advance the model by one accepted byte; on the flagged byte, queue the
    // decoded frame that the block must return and start a fresh frame.
    function automatic void decode_byte(logic [7:0] b, logic is_last);
        sfd_pkg::result_t want;
        int               pos;
        pos = int'(frame_fill);
        if (frame_fill < sfd_pkg::FRAME_BYTES)
        begin
            frame_bits[167 - 8 * pos -: 8] = b;
            if (frame_fill < sfd_pkg::CRC_BYTES)
                frame_crc = crc_next(frame_crc, b);
            frame_fill = frame_fill + 5'd1;
        end
        if (is_last)
        begin
            want = '0;
            // Short buffers win over every other check, then version, then CRC
            if (frame_fill < sfd_pkg::FRAME_BYTES)
                want.status = sfd_pkg::STATUS_SHORT;
            else if (frame_bits[167:160] != version_cfg)
                want.status = sfd_pkg::STATUS_BAD_VERSION;
            else if (frame_crc != frame_bits[15:0])
                want.status = sfd_pkg::STATUS_BAD_CRC;
            else
                want.status = sfd_pkg::STATUS_OK;
            // A short buffer reports every field as zero
            if (want.status != sfd_pkg::STATUS_SHORT)
            begin
                want.frame_version     = frame_bits[167:160];
                want.device_id         = frame_bits[159:144];
                want.sequence_number   = frame_bits[143:128];
                want.uptime_seconds    = frame_bits[127:96];
                want.temperature_centi = frame_bits[95:80];
                want.humidity_centi    = frame_bits[79:64];
                want.pressure_deci_pa  = frame_bits[63:40];
                want.gas_reading       = frame_bits[39:16];
                want.received_crc      = frame_bits[15:0];
            end
            expected_frames.push_back(want);
            clear_frame_model();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Frame construction: 19 body bytes followed by their CRC, big-endian.
    // ------------------------------------------------------------------------
    function automatic byte_q_t build_frame(logic [151:0] body, bit corrupt_crc);
        byte_q_t     q;
        logic [15:0] c;
        c = sfd_pkg::CRC_INIT;
        for (int i = 0; i < 19; i++)
        begin
            q.push_back(body[151 - 8 * i -: 8]);
            c = crc_next(c, body[151 - 8 * i -: 8]);
        end
        // Flip exactly one bit so that the CRC is certain to mismatch
        if (corrupt_crc)
            c = c ^ 16'(1 << $urandom_range(15));
        q.push_back(c[15:8]);
        q.push_back(c[7:0]);
        return q;
    endfunction

    function automatic logic [151:0] random_body(logic [7:0] ver);
        return {ver, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    endfunction

    function automatic byte_q_t random_bytes(int count);
        byte_q_t q;
        for (int i = 0; i < count; i++)
            q.push_back(8'($urandom));
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus: all driving happens just after a falling edge, and a
    // transaction is taken as done at the rising edge where valid and ready
    // are both high.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] data_b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_if.valid = 1'b0;
            @(negedge clk);
        end
        byte_if.valid     = 1'b1;
        byte_if.rx_byte   = data_b;
        byte_if.last_byte = is_last;
        do
            @(posedge clk);
        while (byte_if.ready !== 1'b1);
        decode_byte(data_b, is_last);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send a buffer, flagging its final byte
    task automatic send_buffer(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    // Hold the byte channel quiet until every expected frame is back, then
    // let the block settle before returning.
    task automatic wait_idle();
        byte_if.valid = 1'b0;
        while (expected_frames.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write expected_version; only ever called with the decoder idle
    task automatic write_version(input logic [7:0] ver);
        wait_idle();
        cfg_if.valid = 1'b1;
        cfg_if.data  = ver;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        version_cfg = ver;
        version_writes++;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: drive ready from the stall mix, or hold it low for a
    // counted stretch when a hold-off is requested.
    // ------------------------------------------------------------------------
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                res_if.ready  = 1'b0;
                hold_off_left = hold_off_left - 1;
            end
            else
                res_if.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    always @(posedge clk)
    begin
        sfd_pkg::result_t got;
        sfd_pkg::result_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d frames still expected",
                     cycle_count, expected_frames.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        if (rst_n && byte_if.valid && !byte_if.ready)
            stalled_cycles++;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = '{status            : sfd_pkg::status_t'(res_if.status),
                    frame_version     : res_if.frame_version,
                    device_id         : res_if.device_id,
                    sequence_number   : res_if.sequence_number,
                    uptime_seconds    : res_if.uptime_seconds,
                    temperature_centi : res_if.temperature_centi,
                    humidity_centi    : res_if.humidity_centi,
                    pressure_deci_pa  : res_if.pressure_deci_pa,
                    gas_reading       : res_if.gas_reading,
                    received_crc      : res_if.received_crc};
            frames_seen++;
            status_seen[got.status]++;
            if (expected_frames.size() == 0)
                flag_mismatch("result with no frame expected (status)", '0,
                              32'(got.status));
            else
            begin
                want = expected_frames.pop_front();
                if (got.status !== want.status)
                    flag_mismatch("status", 32'(want.status), 32'(got.status));
                if (got.frame_version !== want.frame_version)
                    flag_mismatch("frame_version", 32'(want.frame_version),
                                  32'(got.frame_version));
                if (got.device_id !== want.device_id)
                    flag_mismatch("device_id", 32'(want.device_id), 32'(got.device_id));
                if (got.sequence_number !== want.sequence_number)
                    flag_mismatch("sequence_number", 32'(want.sequence_number),
                                  32'(got.sequence_number));
                if (got.uptime_seconds !== want.uptime_seconds)
                    flag_mismatch("uptime_seconds", want.uptime_seconds, got.uptime_seconds);
                if (got.temperature_centi !== want.temperature_centi)
                    flag_mismatch("temperature_centi", 32'(want.temperature_centi),
                                  32'(got.temperature_centi));
                if (got.humidity_centi !== want.humidity_centi)
                    flag_mismatch("humidity_centi", 32'(want.humidity_centi),
                                  32'(got.humidity_centi));
                if (got.pressure_deci_pa !== want.pressure_deci_pa)
                    flag_mismatch("pressure_deci_pa", 32'(want.pressure_deci_pa),
                                  32'(got.pressure_deci_pa));
                if (got.gas_reading !== want.gas_reading)
                    flag_mismatch("gas_reading", 32'(want.gas_reading),
                                  32'(got.gas_reading));
                if (got.received_crc !== want.received_crc)
                    flag_mismatch("received_crc", 32'(want.received_crc),
                                  32'(got.received_crc));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Directed frames: field extremes, every status and its priority, short
    // and over-long buffers.
    task automatic test_directed_frames();
        byte_q_t q;
        // Good frame, all fields at their top value (temperature reads as -1)
        send_buffer(build_frame({sfd_pkg::VERSION_INIT, {144{1'b1}}}, 1'b0));
        // Temperature at both signed extremes, other fields mixed
        send_buffer(build_frame({sfd_pkg::VERSION_INIT, 16'h0001, 16'hFFFE, 32'h8000_0001,
                                 16'h8000, 16'h7FFF, 24'h800000, 24'h7FFFFF}, 1'b0));
        send_buffer(build_frame({sfd_pkg::VERSION_INIT, 16'hFFFF, 16'h0000, 32'h7FFF_FFFE,
                                 16'h7FFF, 16'h8000, 24'hFFFFFF, 24'h000001}, 1'b0));
        // CRC mismatch with a good version
        send_buffer(build_frame(random_body(sfd_pkg::VERSION_INIT), 1'b1));
        // Version mismatch outranks a CRC mismatch
        send_buffer(build_frame(random_body(8'h55), 1'b1));
        // Single flagged byte
        send_byte(sfd_pkg::VERSION_INIT, 1'b1);
        // Twenty bytes of an otherwise good frame: short
        q = build_frame(random_body(sfd_pkg::VERSION_INIT), 1'b0);
        void'(q.pop_back());
        send_buffer(q);
        // Short outranks a bad version
        q = build_frame(random_body(8'hAA), 1'b1);
        q = q[0:9];
        send_buffer(q);
        // Trailing run long enough to wrap a five-bit byte counter
        q = build_frame(random_body(sfd_pkg::VERSION_INIT), 1'b0);
        q = {q, random_bytes(20)};
        send_buffer(q);
        // Bad CRC hidden behind trailing bytes
        q = build_frame(random_body(sfd_pkg::VERSION_INIT), 1'b1);
        q = {q, random_bytes(2)};
        send_buffer(q);
        wait_idle();
    endtask

    // Expected version register at both extremes, each with a matching and a
    // mismatching frame.
    task automatic test_version_register();
        logic [7:0] settings[2];
        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        foreach (settings[i])
        begin
            write_version(settings[i]);
            send_buffer(build_frame(random_body(settings[i]), 1'b0));
            send_buffer(build_frame(random_body(settings[i] ^ 8'h01), 1'b0));
        end
        wait_idle();
    endtask

    // Back-pressure: hold the receiver off for a long stretch while the byte
    // channel keeps offering single-byte buffers, so that the output register
    // and its skid entry fill and the byte channel stalls.
    task automatic test_output_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 400;
        repeat (12)
            send_byte(8'($urandom), 1'b1);
        send_buffer(build_frame(random_body(version_cfg), 1'b0));
        wait_idle();
    endtask

    // Random traffic: mostly well-formed frames with random content, the rest
    // corrupt CRCs, wrong versions, short buffers and over-long noise.
    task automatic test_random_traffic();
        int         idle_mix[3][2];
        int         phase_start;
        int         frames_start;
        int         kind;
        logic [7:0] ver;
        byte_q_t    q;
        idle_mix = '{'{9, 87}, '{87, 9}, '{0, 0}};
        for (int ph = 0; ph < 3; ph++)
        begin
            write_version(ph == 2 ? sfd_pkg::VERSION_INIT : 8'($urandom));
            send_idle_pct  = idle_mix[ph][0];
            recv_stall_pct = idle_mix[ph][1];
            phase_start  = bytes_sent;
            frames_start = frames_seen + expected_frames.size();
            while (bytes_sent - phase_start < RANDOM_PHASE_N ||
                   frames_seen + expected_frames.size() - frames_start < PHASE_FRAMES)
            begin
                kind = $urandom_range(99);
                if (kind < 55)
                begin
                    q = build_frame(random_body(version_cfg), 1'b0);
                    if ($urandom_range(4) == 0)
                        q = {q, random_bytes($urandom_range(1, 3))};
                end
                else if (kind < 65)
                    q = build_frame(random_body(version_cfg), 1'b1);
                else if (kind < 75)
                begin
                    do
                        ver = 8'($urandom);
                    while (ver == version_cfg);
                    q = build_frame(random_body(ver), 1'($urandom_range(1)));
                end
                else if (kind < 92)
                    q = random_bytes($urandom_range(1, 20));
                else
                    q = random_bytes($urandom_range(22, 45));
                send_buffer(q);
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        byte_if.valid     = 1'b0;
        byte_if.rx_byte   = '0;
        byte_if.last_byte = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_off_left     = 0;
        version_cfg       = sfd_pkg::VERSION_INIT;
        clear_frame_model();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_frames();
        test_version_register();
        test_output_stall();
        test_random_traffic();

        wait_idle();
        repeat (10) @(negedge clk);

        $display("Covered %0d bytes over %0d version settings; %0d cycles with bytes stalled",
                 bytes_sent, version_writes, stalled_cycles);
        $display("Decoded %0d frames: %0d ok, %0d short, %0d bad version, %0d bad CRC",
                 frames_seen, status_seen[sfd_pkg::STATUS_OK],
                 status_seen[sfd_pkg::STATUS_SHORT],
                 status_seen[sfd_pkg::STATUS_BAD_VERSION],
                 status_seen[sfd_pkg::STATUS_BAD_CRC]);
        if (mismatches == 0 && expected_frames.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
